>>> rtl/core/rbs_pkg.sv
// Package for the reconnect backoff supervisor: beat structs, config struct,
// event codes, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package rbs_pkg;

    // event codes carried in the func field
    localparam logic [2:0] EV_START          = 3'd0;
    localparam logic [2:0] EV_STOP           = 3'd1;
    localparam logic [2:0] EV_LINK_UP        = 3'd2;
    localparam logic [2:0] EV_LINK_LOST      = 3'd3;
    localparam logic [2:0] EV_DEADLINE_EXP   = 3'd4;
    localparam logic [2:0] EV_RETRY_EXP      = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_FIRST_DELAY   = 3'd0;
    localparam logic [2:0] REG_GROWTH        = 3'd1;
    localparam logic [2:0] REG_MAX_DELAY     = 3'd2;
    localparam logic [2:0] REG_JITTER        = 3'd3;
    localparam logic [2:0] REG_TIMEOUT       = 3'd4;

    // configuration reset values
    localparam logic [30:0] FIRST_DELAY_RST  = 31'd250;
    localparam logic [7:0]  GROWTH_RST       = 8'd2;
    localparam logic [30:0] MAX_DELAY_RST    = 31'd30000;
    localparam logic [15:0] JITTER_RST       = 16'd0;
    localparam logic [30:0] TIMEOUT_RST      = 31'd5000;

    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  func;
        logic        attached_now;
        logic        socket_found;
        logic [15:0] jitter_draw;
    } in_beat_t;

    typedef struct packed {
        logic        connect_now;
        logic [30:0] deadline_ms;
        logic        arm_retry;
        logic [31:0] retry_delay_ms;
        logic        stop_deadline;
        logic        stop_retry;
        logic        lost_report;
        logic        attached_report;
        logic [15:0] attempt_number;
        logic        waiting_retry;
    } out_beat_t;

    typedef struct packed {
        logic [30:0] first_delay_ms;
        logic [7:0]  growth_factor;
        logic [30:0] maximum_delay_ms;
        logic [15:0] jitter_ms;
        logic [30:0] attempt_timeout_ms;
    } cfg_t;

endpackage

>>> rtl/core/reconnect_backoff_supervisor_core.sv
// Top level of the reconnect backoff supervisor: input and result registers,
// handshake control and checks. Depends on rbs_pkg, rbs_cfg_regs, rbs_engine.
`timescale 1ns / 1ps

// Supervises one link with capped exponential backoff and jitter.
// Input channel s_*: one event beat (func, attached_now, socket_found,
// jitter_draw) per handshake. Result channel m_*: exactly one command beat per
// event, in order. Configuration: cfg_we / cfg_index / cfg_wdata write one
// register per cycle, no wait, and should only be used while the block is idle.
// A beat accepted is held in the input register, processed in one pass and
// moves into the result register, raising m_valid, once it is free.
// Throughput: one beat per cycle while the receiver does not stall; the state
// update (one 31x8 multiply, a compare and an add) settles in the single step
// from input to result register. When the receiver stalls, the result register
// holds its beat, the input register fills with the next beat and s_ready then
// drops until m_ready returns. Reset (aresetn low, synchronous) empties both
// registers, clears the supervisor state and restores the configuration reset
// values.
module reconnect_backoff_supervisor_core import rbs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wdata
);

    cfg_t      cfg;
    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg;
    out_beat_t step_beat;
    logic      advance;

    rbs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rbs_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .in_beat  (in_data_reg),
        .cfg      (cfg),
        .out_beat (step_beat)
    );

    // beat moves from input to result register when the latter is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_beat;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a retry is only armed when it leaves the block waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.arm_retry || m_data.waiting_retry))
        else $error("retry armed without waiting flag");

    // connecting and backing off never happen for the same event
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.connect_now && m_data.arm_retry))
        else $error("connect and retry in one beat");

    // an attach clears the count and the pending retry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.attached_report) |->
            (m_data.attempt_number == 16'd0 && !m_data.waiting_retry))
        else $error("attach left count or retry pending");

    // both registers full and stalled: no new beat may enter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline is full");

endmodule

>>> rtl/core/rbs_cfg_regs.sv
// Configuration register file of the reconnect backoff supervisor.
// Depends on rbs_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module rbs_cfg_regs import rbs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write into the addressed field, unknown indexes ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FIRST_DELAY: cfg_next.first_delay_ms     = cfg_wdata;
                REG_GROWTH:      cfg_next.growth_factor      = cfg_wdata[7:0];
                REG_MAX_DELAY:   cfg_next.maximum_delay_ms   = cfg_wdata;
                REG_JITTER:      cfg_next.jitter_ms          = cfg_wdata[15:0];
                REG_TIMEOUT:     cfg_next.attempt_timeout_ms = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_delay_ms     <= FIRST_DELAY_RST;
            cfg_reg.growth_factor      <= GROWTH_RST;
            cfg_reg.maximum_delay_ms   <= MAX_DELAY_RST;
            cfg_reg.jitter_ms          <= JITTER_RST;
            cfg_reg.attempt_timeout_ms <= TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/rbs_engine.sv
// Supervisor state and the single-pass event logic: one event beat in,
// one command beat out, state updated when the beat moves on.
// Depends on rbs_pkg for the beat and config structs and event codes.
`timescale 1ns / 1ps

module rbs_engine import rbs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_beat_t  in_beat,
    input  cfg_t      cfg,
    output out_beat_t out_beat
);

    logic        running_reg, running_next;
    logic        waiting_reg, waiting_next;
    logic        att_before_reg, att_before_next;
    logic        loss_rep_reg, loss_rep_next;
    logic [15:0] count_reg, count_next;
    logic [39:0] base_reg, base_next;

    logic        is_start;
    logic [39:0] sched_base;
    logic        below_max;
    logic [30:0] delay_capped;
    logic [7:0]  growth_eff;
    logic [38:0] product;
    logic [39:0] base_grown;
    logic [15:0] jitter_clamped;
    logic [31:0] retry_sum;

    // backoff datapath: cap, grow once, add clamped jitter
    assign is_start       = (in_beat.func == EV_START);
    assign sched_base     = is_start ? {9'd0, cfg.first_delay_ms} : base_reg;
    assign below_max      = sched_base < {9'd0, cfg.maximum_delay_ms};
    assign delay_capped   = below_max ? sched_base[30:0] : cfg.maximum_delay_ms;
    assign growth_eff     = (cfg.growth_factor == 8'd0) ? 8'd1 : cfg.growth_factor;
    assign product        = {8'd0, sched_base[30:0]} * {31'd0, growth_eff};
    assign base_grown     = below_max ? {1'b0, product} : sched_base;
    assign jitter_clamped = (in_beat.jitter_draw < cfg.jitter_ms) ? in_beat.jitter_draw
                                                                  : cfg.jitter_ms;
    assign retry_sum      = {1'b0, delay_capped} + {16'd0, jitter_clamped};

    // event decode and state update
    always_comb begin
        logic do_attempt;
        logic do_check;
        logic do_sched;
        out_beat_t cmd;

        running_next    = running_reg;
        waiting_next    = waiting_reg;
        att_before_next = att_before_reg;
        loss_rep_next   = loss_rep_reg;
        count_next      = count_reg;
        base_next       = base_reg;
        do_attempt      = 1'b0;
        do_check        = 1'b0;
        do_sched        = 1'b0;
        cmd             = '0;

        case (in_beat.func)
            EV_START: begin
                running_next    = 1'b1;
                att_before_next = 1'b0;
                loss_rep_next   = 1'b0;
                count_next      = 16'd0;
                base_next       = {9'd0, cfg.first_delay_ms};
                do_attempt      = 1'b1;
            end
            EV_STOP: begin
                running_next      = 1'b0;
                waiting_next      = 1'b0;
                cmd.stop_retry    = 1'b1;
                cmd.stop_deadline = 1'b1;
            end
            EV_LINK_UP: begin
                do_check = running_reg && in_beat.attached_now;
            end
            EV_LINK_LOST: begin
                if (running_reg && !in_beat.attached_now) begin
                    if (att_before_reg && !loss_rep_reg) begin
                        loss_rep_next   = 1'b1;
                        cmd.lost_report = 1'b1;
                    end
                    do_sched = !waiting_reg;
                end
            end
            EV_DEADLINE_EXP: begin
                do_sched = running_reg && !waiting_reg;
            end
            EV_RETRY_EXP: begin
                do_attempt = running_reg;
            end
            default: begin
                do_attempt = 1'b0;
            end
        endcase

        // connection attempt: attach check, or count up and connect / back off
        if (do_attempt) begin
            cmd.stop_retry = 1'b1;
            waiting_next   = 1'b0;
            if (in_beat.attached_now) begin
                do_check = 1'b1;
            end else begin
                if (count_next != COUNT_MAX) begin
                    count_next = count_next + 16'd1;
                end
                if (!in_beat.socket_found) begin
                    do_sched = 1'b1;
                end else begin
                    cmd.connect_now = 1'b1;
                    cmd.deadline_ms = cfg.attempt_timeout_ms;
                end
            end
        end

        // link attached: clear counters and backoff
        if (do_check) begin
            cmd.stop_deadline   = 1'b1;
            cmd.stop_retry      = 1'b1;
            waiting_next        = 1'b0;
            count_next          = 16'd0;
            base_next           = {9'd0, cfg.first_delay_ms};
            att_before_next     = 1'b1;
            loss_rep_next       = 1'b0;
            cmd.attached_report = 1'b1;
        end

        // arm the retry timer with the capped delay
        if (do_sched) begin
            cmd.stop_deadline  = 1'b1;
            waiting_next       = 1'b1;
            base_next          = base_grown;
            cmd.arm_retry      = 1'b1;
            cmd.retry_delay_ms = retry_sum;
        end

        cmd.attempt_number = count_next;
        cmd.waiting_retry  = waiting_next;
        out_beat           = cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= 1'b0;
            waiting_reg    <= 1'b0;
            att_before_reg <= 1'b0;
            loss_rep_reg   <= 1'b0;
            count_reg      <= 16'd0;
            base_reg       <= 40'd0;
        end else if (step_en) begin
            running_reg    <= running_next;
            waiting_reg    <= waiting_next;
            att_before_reg <= att_before_next;
            loss_rep_reg   <= loss_rep_next;
            count_reg      <= count_next;
            base_reg       <= base_next;
        end
    end

endmodule

>>> tb/tb_reconnect_backoff_supervisor_core.sv
// Self-checking testbench for reconnect_backoff_supervisor_core: event beats in,
// command beats out, each checked against an in-bench model of the supervisor.
// Depends on rbs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_reconnect_backoff_supervisor_core;
    import rbs_pkg::*;

    // event codes the block leaves undefined
    localparam logic [2:0] EV_SPARE_6 = 3'd6;
    localparam logic [2:0] EV_SPARE_7 = 3'd7;

    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_CYCLES = 4;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_wdata = '0;

    reconnect_backoff_supervisor_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow of the configuration registers
    cfg_t shadow_cfg = '{first_delay_ms: FIRST_DELAY_RST, growth_factor: GROWTH_RST,
                         maximum_delay_ms: MAX_DELAY_RST, jitter_ms: JITTER_RST,
                         attempt_timeout_ms: TIMEOUT_RST};

    // supervisor state as the model tracks it
    logic        run_flag = 1'b0;
    logic        wait_flag = 1'b0;
    logic        was_attached = 1'b0;
    logic        loss_flagged = 1'b0;
    logic [15:0] attempts = '0;
    logic [63:0] base_delay = '0;
    out_beat_t   next_cmd;

    out_beat_t expected_cmds[$];
    out_beat_t want;
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    // arm a retry unless stopped or one is already pending
    function automatic void schedule_retry(logic [15:0] draw);
        logic [63:0] delay;
        logic [15:0] jit;
        logic [63:0] grow;
        if (!run_flag || wait_flag) return;
        next_cmd.stop_deadline = 1'b1;
        wait_flag = 1'b1;
        delay = (base_delay < {33'd0, shadow_cfg.maximum_delay_ms}) ?
                base_delay : {33'd0, shadow_cfg.maximum_delay_ms};
        grow = (shadow_cfg.growth_factor == 8'd0) ? 64'd1 : {56'd0, shadow_cfg.growth_factor};
        if (base_delay < {33'd0, shadow_cfg.maximum_delay_ms})
            base_delay = base_delay * grow;
        jit = (draw < shadow_cfg.jitter_ms) ? draw : shadow_cfg.jitter_ms;
        next_cmd.arm_retry = 1'b1;
        next_cmd.retry_delay_ms = 32'(delay + {48'd0, jit});
    endfunction

    // link came up: clear counters and report attach
    function automatic void mark_attached(logic att);
        if (!run_flag || !att) return;
        next_cmd.stop_deadline = 1'b1;
        next_cmd.stop_retry = 1'b1;
        wait_flag = 1'b0;
        attempts = '0;
        base_delay = {33'd0, shadow_cfg.first_delay_ms};
        was_attached = 1'b1;
        loss_flagged = 1'b0;
        next_cmd.attached_report = 1'b1;
    endfunction

    // one connection attempt
    function automatic void try_connect(logic att, logic sock, logic [15:0] draw);
        if (!run_flag) return;
        next_cmd.stop_retry = 1'b1;
        wait_flag = 1'b0;
        if (att) begin
            mark_attached(att);
            return;
        end
        if (attempts != COUNT_MAX) attempts = attempts + 16'd1;
        if (!sock) begin
            schedule_retry(draw);
            return;
        end
        next_cmd.connect_now = 1'b1;
        next_cmd.deadline_ms = shadow_cfg.attempt_timeout_ms;
    endfunction

    // command word the supervisor should answer one event with
    function automatic out_beat_t supervise_event(in_beat_t ev);
        next_cmd = '0;
        case (ev.func)
            EV_START: begin
                run_flag = 1'b1;
                was_attached = 1'b0;
                loss_flagged = 1'b0;
                attempts = '0;
                base_delay = {33'd0, shadow_cfg.first_delay_ms};
                try_connect(ev.attached_now, ev.socket_found, ev.jitter_draw);
            end
            EV_STOP: begin
                run_flag = 1'b0;
                wait_flag = 1'b0;
                next_cmd.stop_retry = 1'b1;
                next_cmd.stop_deadline = 1'b1;
            end
            EV_LINK_UP: mark_attached(ev.attached_now);
            EV_LINK_LOST: begin
                if (run_flag && !ev.attached_now) begin
                    if (was_attached && !loss_flagged) begin
                        loss_flagged = 1'b1;
                        next_cmd.lost_report = 1'b1;
                    end
                    schedule_retry(ev.jitter_draw);
                end
            end
            EV_DEADLINE_EXP: schedule_retry(ev.jitter_draw);
            EV_RETRY_EXP: try_connect(ev.attached_now, ev.socket_found, ev.jitter_draw);
            default: ;
        endcase
        next_cmd.attempt_number = attempts;
        next_cmd.waiting_retry = wait_flag;
        return next_cmd;
    endfunction

    function automatic in_beat_t make_event(logic [2:0] f, logic att, logic sock,
                                            logic [15:0] draw);
        in_beat_t ev;
        ev.func = f;
        ev.attached_now = att;
        ev.socket_found = sock;
        ev.jitter_draw = draw;
        return ev;
    endfunction

    // mostly retry and deadline traffic on a running link, some stops and noise
    function automatic in_beat_t random_event();
        in_beat_t ev;
        int pick;
        pick = $urandom_range(99);
        if (pick < 6) ev.func = EV_START;
        else if (pick < 10) ev.func = EV_STOP;
        else if (pick < 22) ev.func = EV_LINK_UP;
        else if (pick < 38) ev.func = EV_LINK_LOST;
        else if (pick < 60) ev.func = EV_DEADLINE_EXP;
        else if (pick < 97) ev.func = EV_RETRY_EXP;
        else ev.func = $urandom_range(1) ? EV_SPARE_6 : EV_SPARE_7;
        ev.attached_now = ($urandom_range(99) < 20);
        ev.socket_found = 1'($urandom_range(1));
        ev.jitter_draw = ($urandom_range(3) == 0) ? 16'($urandom_range(600))
                                                  : 16'($urandom);
        return ev;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        case ($urandom_range(9))
            0: c.first_delay_ms = '0;
            1: c.first_delay_ms = MAX31;
            2: c.first_delay_ms = 31'($urandom);
            default: c.first_delay_ms = 31'($urandom_range(1, 2000));
        endcase
        case ($urandom_range(9))
            0: c.growth_factor = '0;
            1: c.growth_factor = 8'hFF;
            2: c.growth_factor = 8'($urandom);
            default: c.growth_factor = 8'($urandom_range(1, 4));
        endcase
        case ($urandom_range(9))
            0: c.maximum_delay_ms = '0;
            1: c.maximum_delay_ms = MAX31;
            2: c.maximum_delay_ms = 31'($urandom);
            default: c.maximum_delay_ms = 31'($urandom_range(0, 200000));
        endcase
        case ($urandom_range(9))
            0: c.jitter_ms = '0;
            1: c.jitter_ms = 16'hFFFF;
            2: c.jitter_ms = 16'($urandom);
            default: c.jitter_ms = 16'($urandom_range(0, 500));
        endcase
        case ($urandom_range(9))
            0: c.attempt_timeout_ms = '0;
            1: c.attempt_timeout_ms = MAX31;
            default: c.attempt_timeout_ms = 31'($urandom);
        endcase
        return c;
    endfunction

    // offer one event beat, with random idle cycles ahead of it
    task automatic send_event(input in_beat_t ev);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= ev;
        do @(posedge aclk); while (!s_ready);
        expected_cmds.push_back(supervise_event(ev));
    endtask

    // stop offering and let every pending command beat drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FIRST_DELAY: shadow_cfg.first_delay_ms = value;
            REG_GROWTH:      shadow_cfg.growth_factor = value[7:0];
            REG_MAX_DELAY:   shadow_cfg.maximum_delay_ms = value;
            REG_JITTER:      shadow_cfg.jitter_ms = value[15:0];
            REG_TIMEOUT:     shadow_cfg.attempt_timeout_ms = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_config(input cfg_t c);
        wait_idle();
        write_reg(REG_FIRST_DELAY, c.first_delay_ms);
        write_reg(REG_GROWTH, {23'd0, c.growth_factor});
        write_reg(REG_MAX_DELAY, c.maximum_delay_ms);
        write_reg(REG_JITTER, {15'd0, c.jitter_ms});
        write_reg(REG_TIMEOUT, c.attempt_timeout_ms);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_event(random_event());
    endtask

    // hand-picked events on the reset configuration
    task automatic test_directed_events();
        send_event(make_event(EV_SPARE_7, 1'b1, 1'b1, 16'hFFFF));
        send_event(make_event(EV_LINK_UP, 1'b1, 1'b0, 16'h0000));
        send_event(make_event(EV_LINK_LOST, 1'b0, 1'b0, 16'h0000));
        send_event(make_event(EV_DEADLINE_EXP, 1'b0, 1'b0, 16'h0000));
        send_event(make_event(EV_RETRY_EXP, 1'b0, 1'b1, 16'h0000));
        send_event(make_event(EV_START, 1'b0, 1'b0, 16'hFFFF));
        send_event(make_event(EV_DEADLINE_EXP, 1'b0, 1'b0, 16'h0000));
        send_event(make_event(EV_RETRY_EXP, 1'b0, 1'b1, 16'h0000));
        send_event(make_event(EV_DEADLINE_EXP, 1'b0, 1'b0, 16'h0000));
        send_event(make_event(EV_RETRY_EXP, 1'b0, 1'b0, 16'h5A5A));
        send_event(make_event(EV_LINK_UP, 1'b0, 1'b1, 16'h0000));
        send_event(make_event(EV_LINK_UP, 1'b1, 1'b1, 16'h0000));
        send_event(make_event(EV_LINK_LOST, 1'b1, 1'b0, 16'h0000));
        send_event(make_event(EV_LINK_LOST, 1'b0, 1'b0, 16'hFFFF));
        send_event(make_event(EV_LINK_LOST, 1'b0, 1'b1, 16'hA5A5));
        send_event(make_event(EV_RETRY_EXP, 1'b1, 1'b0, 16'h0000));
        send_event(make_event(EV_SPARE_6, 1'b0, 1'b0, 16'h0000));
        send_event(make_event(EV_STOP, 1'b0, 1'b0, 16'h0000));
        send_event(make_event(EV_START, 1'b1, 1'b1, 16'h0000));
        send_event(make_event(EV_STOP, 1'b1, 1'b1, 16'hFFFF));
    endtask

    // corner settings of the registers, each followed by a short run
    task automatic test_register_extremes();
        cfg_t settings[5];
        settings[0] = '0;
        settings[1] = '{first_delay_ms: MAX31, growth_factor: 8'hFF, maximum_delay_ms: MAX31,
                        jitter_ms: 16'hFFFF, attempt_timeout_ms: MAX31};
        settings[2] = '{first_delay_ms: 31'd7, growth_factor: 8'd0, maximum_delay_ms: 31'd100,
                        jitter_ms: 16'd3, attempt_timeout_ms: 31'd1};
        settings[3] = '{first_delay_ms: 31'd1, growth_factor: 8'hFF, maximum_delay_ms: MAX31,
                        jitter_ms: 16'h8000, attempt_timeout_ms: 31'h5555_5555};
        settings[4] = '{first_delay_ms: FIRST_DELAY_RST, growth_factor: GROWTH_RST,
                        maximum_delay_ms: MAX_DELAY_RST, jitter_ms: JITTER_RST,
                        attempt_timeout_ms: TIMEOUT_RST};
        foreach (settings[i]) begin
            apply_config(settings[i]);
            send_event(make_event(EV_START, 1'b0, 1'b0, 16'($urandom)));
            // a long unbroken retry chain drives the base up to the cap
            repeat (12) begin
                send_event(make_event(EV_RETRY_EXP, 1'b0, 1'b0, 16'($urandom)));
            end
            send_random(30);
        end
    endtask

    // four idling phases, registers re-drawn every 100 events
    task automatic test_random_traffic();
        int phase_send[4] = '{0, 66, 0, 8};
        int phase_recv[4] = '{0, 0, 66, 8};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            repeat (4) begin
                apply_config(random_config());
                send_random(100);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits
    task automatic test_backpressure();
        wait_idle();
        hold_left = 300;
        send_random(40);
        wait_idle();
        send_random(40);
    endtask

    // long unbroken run of connect attempts, count climbs without a reset
    task automatic test_attempt_chain();
        apply_config(random_config());
        send_event(make_event(EV_START, 1'b0, 1'b1, 16'h0000));
        repeat (200) begin
            send_event(make_event(EV_RETRY_EXP, 1'b0, 1'b1, 16'($urandom)));
        end
        send_event(make_event(EV_RETRY_EXP, 1'b0, 1'b0, 16'($urandom)));
        send_event(make_event(EV_DEADLINE_EXP, 1'b0, 1'b0, 16'($urandom)));
        send_event(make_event(EV_LINK_UP, 1'b1, 1'b0, 16'h0000));
        send_event(make_event(EV_STOP, 1'b0, 1'b0, 16'h0000));
    endtask

    // check each command beat and drive m_ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_cmds.size() == 0) begin
                $error("command beat with no event pending");
                mismatches++;
            end else begin
                want = expected_cmds.pop_front();
                if (m_data.connect_now !== want.connect_now) begin
                    $error("connect_now expected %0d got %0d",
                           want.connect_now, m_data.connect_now);
                    mismatches++;
                end
                if (m_data.deadline_ms !== want.deadline_ms) begin
                    $error("deadline_ms expected %0d got %0d",
                           want.deadline_ms, m_data.deadline_ms);
                    mismatches++;
                end
                if (m_data.arm_retry !== want.arm_retry) begin
                    $error("arm_retry expected %0d got %0d", want.arm_retry, m_data.arm_retry);
                    mismatches++;
                end
                if (m_data.retry_delay_ms !== want.retry_delay_ms) begin
                    $error("retry_delay_ms expected %0d got %0d",
                           want.retry_delay_ms, m_data.retry_delay_ms);
                    mismatches++;
                end
                if (m_data.stop_deadline !== want.stop_deadline) begin
                    $error("stop_deadline expected %0d got %0d",
                           want.stop_deadline, m_data.stop_deadline);
                    mismatches++;
                end
                if (m_data.stop_retry !== want.stop_retry) begin
                    $error("stop_retry expected %0d got %0d", want.stop_retry, m_data.stop_retry);
                    mismatches++;
                end
                if (m_data.lost_report !== want.lost_report) begin
                    $error("lost_report expected %0d got %0d",
                           want.lost_report, m_data.lost_report);
                    mismatches++;
                end
                if (m_data.attached_report !== want.attached_report) begin
                    $error("attached_report expected %0d got %0d",
                           want.attached_report, m_data.attached_report);
                    mismatches++;
                end
                if (m_data.attempt_number !== want.attempt_number) begin
                    $error("attempt_number expected %0d got %0d",
                           want.attempt_number, m_data.attempt_number);
                    mismatches++;
                end
                if (m_data.waiting_retry !== want.waiting_retry) begin
                    $error("waiting_retry expected %0d got %0d",
                           want.waiting_retry, m_data.waiting_retry);
                    mismatches++;
                end
            end
        end
        // long hold-off first, random stalls otherwise
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: too long without a beat on either channel
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // test sequence
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_events();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_attempt_chain();
        wait_idle();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
